[rtl/core/fwt_pkg.sv]
// ----------------------------------------------------------------------------
// Futex waiter table package
// Shared constants, payload structs and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package fwt_pkg;

  localparam int unsigned ENTRIES   = 256;
  localparam int unsigned PROC_BITS = 8;
  localparam int unsigned IDX_W     = $clog2(ENTRIES);
  localparam int unsigned CNT_W     = $clog2(ENTRIES + 1);
  localparam int unsigned WOKEN_MAX = 511;

  localparam logic [1:0] CMD_WAIT  = 2'd0;
  localparam logic [1:0] CMD_WAKE  = 2'd1;
  localparam logic [1:0] CMD_LEAVE = 2'd2;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_FAULT       = 3'd1;
  localparam logic [2:0] ST_MISMATCH    = 3'd2;
  localparam logic [2:0] ST_FULL        = 3'd3;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  proc_id;
    logic [63:0] word_addr;
    logic        addr_ok;
    logic [31:0] word_now;
    logic [31:0] value;
  } fwt_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [8:0] woken;
  } fwt_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic scan_start;
    logic scan_en;
    logic load_rsp;
  } fwt_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_scan;
    logic scan_done;
  } fwt_sts_t;

endpackage

`default_nettype wire

[rtl/core/fwt_datapath.sv]
// ----------------------------------------------------------------------------
// Futex waiter table datapath
// Request register, slot scan pipeline, entry memories and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fwt_datapath import fwt_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire fwt_req_t req_i,
  input  wire fwt_ctl_t ctl_i,
  output fwt_sts_t      sts_o,
  output fwt_rsp_t      rsp_o
);

  fwt_req_t               req_q;
  logic [ENTRIES-1:0]     busy_q;
  logic [IDX_W-1:0]       rd_idx_q;
  logic                   issued_all_q;
  logic                   s1_valid_q;
  logic [IDX_W-1:0]       s1_idx_q;
  logic                   s1_busy_q;
  logic [63:0]            s1_addr_q;
  logic [PROC_BITS-1:0]   s1_proc_q;
  logic [CNT_W-1:0]       woken_q;
  logic [2:0]             status_q;
  fwt_rsp_t               rsp_q;

  logic [63:0]            mem_addr [ENTRIES];
  logic [PROC_BITS-1:0]   mem_proc [ENTRIES];

  logic                   bad_addr;
  logic                   need_scan;
  logic [2:0]             pre_status;
  logic [PROC_BITS-1:0]   pid;
  logic                   act;
  logic                   hit;
  logic                   last_slot;
  logic                   wake_full;
  logic                   do_issue;

  assign pid      = req_q.proc_id[PROC_BITS-1:0];
  assign bad_addr = !req_q.addr_ok || (req_q.word_addr[1:0] != 2'b00);

  // Classify the held request before any slot is touched.
  always_comb begin
    need_scan  = 1'b0;
    pre_status = ST_OK;
    if (req_q.cmd == CMD_LEAVE) begin
      need_scan = 1'b1;
    end else if (bad_addr) begin
      pre_status = ST_FAULT;
    end else begin
      case (req_q.cmd)
        CMD_WAIT: begin
          if (req_q.word_now != req_q.value) begin
            pre_status = ST_MISMATCH;
          end else begin
            pre_status = ST_FULL;
            need_scan  = 1'b1;
          end
        end
        CMD_WAKE: begin
          need_scan = !req_q.value[31] && (req_q.value != 32'd0);
        end
        default: begin
          pre_status = ST_UNSUPPORTED;
        end
      endcase
    end
  end

  assign act       = ctl_i.scan_en && s1_valid_q;
  assign last_slot = (s1_idx_q == IDX_W'(ENTRIES - 1));
  assign wake_full = (32'(woken_q) + 32'd1) == req_q.value;

  always_comb begin
    case (req_q.cmd)
      CMD_WAIT: hit = !s1_busy_q;
      CMD_WAKE: hit = s1_busy_q && (s1_addr_q == req_q.word_addr);
      default:  hit = s1_busy_q && (s1_proc_q == pid);
    endcase
  end

  assign do_issue         = ctl_i.scan_en && !issued_all_q;
  assign sts_o.need_scan  = need_scan;
  assign sts_o.scan_done  = act && (last_slot || (hit && ((req_q.cmd != CMD_WAKE) || wake_full)));

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_req) begin
      req_q <= req_i;
    end
  end

  // Entry memories: one write port at the evaluated slot, one registered read.
  always_ff @(posedge clk_i) begin
    if (act && hit && (req_q.cmd == CMD_WAIT)) begin
      mem_addr[s1_idx_q] <= req_q.word_addr;
      mem_proc[s1_idx_q] <= pid;
    end
    s1_addr_q <= mem_addr[rd_idx_q];
    s1_proc_q <= mem_proc[rd_idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= '0;
      rd_idx_q     <= '0;
      issued_all_q <= 1'b0;
      s1_valid_q   <= 1'b0;
      s1_idx_q     <= '0;
      s1_busy_q    <= 1'b0;
      woken_q      <= '0;
      status_q     <= ST_OK;
    end else begin
      if (ctl_i.scan_start) begin
        rd_idx_q     <= '0;
        issued_all_q <= 1'b0;
        s1_valid_q   <= 1'b0;
        woken_q      <= '0;
        status_q     <= pre_status;
      end else begin
        s1_valid_q <= do_issue;
        if (do_issue) begin
          s1_idx_q  <= rd_idx_q;
          s1_busy_q <= busy_q[rd_idx_q];
          rd_idx_q  <= rd_idx_q + IDX_W'(1);
          if (rd_idx_q == IDX_W'(ENTRIES - 1)) begin
            issued_all_q <= 1'b1;
          end
        end
        if (act && hit) begin
          busy_q[s1_idx_q] <= (req_q.cmd == CMD_WAIT);
          if (req_q.cmd == CMD_WAIT) begin
            status_q <= ST_OK;
          end
          if (req_q.cmd == CMD_WAKE) begin
            woken_q <= woken_q + CNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_rsp) begin
      rsp_q.status <= status_q;
      if (32'(woken_q) > 32'(WOKEN_MAX)) begin
        rsp_q.woken <= 9'(WOKEN_MAX);
      end else begin
        rsp_q.woken <= 9'(woken_q);
      end
    end
  end

  assign rsp_o = rsp_q;

endmodule

`default_nettype wire

[rtl/core/fwt_ctrl.sv]
// ----------------------------------------------------------------------------
// Futex waiter table controller
// Sequences accept, classify, slot scan and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module fwt_ctrl import fwt_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  input  wire fwt_sts_t sts_i,
  output fwt_ctl_t      ctl_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECIDE = 4'b0010,
    S_SCAN   = 4'b0100,
    S_RESP   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   rsp_free;

  assign rsp_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d          = state_q;
    ctl_o            = '0;
    ctl_o.load_req   = (state_q == S_IDLE) && in_valid_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        ctl_o.scan_start = 1'b1;
        state_d          = sts_i.need_scan ? S_SCAN : S_RESP;
      end
      S_SCAN: begin
        ctl_o.scan_en = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        // Hold the result until the output register can take it.
        if (rsp_free) begin
          ctl_o.load_rsp = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_o.load_rsp) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.load_rsp |-> (!out_valid_q || !out_stall_i))
    else $error("result register loaded while a stalled word is held");

  a_accept_decides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_DECIDE))
    else $error("accepted word not classified in the next cycle");

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SCAN) && sts_i.scan_done) |=> (state_q == S_RESP))
    else $error("finished scan did not move to the result state");

endmodule

`default_nettype wire

[rtl/core/futex_waiter_table_top.sv]
// Wait, wake and leave requests walk the table slot by slot, and a scan can stop before the
// last slot. Faults, mismatches, zero or negative wake counts and the unsupported command
// answer without a scan. One request is in flight at a time. The next word is accepted in
// the cycle after the result loads. Reset clears every busy bit at once in flip-flops; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
// Futex waiter table top level
// Wait/wake/leave table of waiting processes keyed by futex word address.
// ----------------------------------------------------------------------------
`default_nettype none

module futex_waiter_table_top import fwt_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire fwt_req_t in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output fwt_rsp_t      out_rsp_o
);

  fwt_ctl_t ctl;
  fwt_sts_t sts;

  fwt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  fwt_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_req_i),
    .ctl_i  (ctl),
    .sts_o  (sts),
    .rsp_o  (out_rsp_o)
  );

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// Futex waiter table testbench
// Drives wait, wake and leave request words into the table and checks every
// reply word against an in-bench model of the waiter slots. A short directed
// table comes first, then random traffic under three sender and receiver
// idling mixes, including a full-table fill and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb import fwt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_BAD     = 2'd3;
  localparam int         HOLD_CYCLES = 2000;
  localparam int         DRAIN_WAIT  = 300;
  localparam longint     CYCLE_LIMIT = 4000000;
  localparam int         PHASE_ITEMS = 450;
  localparam int         NDIR        = 18;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  fwt_req_t in_req_i;
  logic     out_valid_o;
  logic     out_stall_i;
  fwt_rsp_t out_rsp_o;

  futex_waiter_table_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  // Shadow copy of the waiter slots.
  bit                   slot_busy [ENTRIES];
  logic [PROC_BITS-1:0] slot_proc [ENTRIES];
  logic [63:0]          slot_addr [ENTRIES];

  fwt_rsp_t    replies_due [$];
  logic [63:0] addr_pool [8];
  logic [7:0]  proc_pool [16];

  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     hold_seq      = 0;
  int     errors        = 0;
  int     words_sent    = 0;
  int     replies_seen  = 0;
  int     full_replies  = 0;
  int     most_woken    = 0;
  longint cycles        = 0;

  typedef struct {
    logic [1:0]  cmd;
    logic [7:0]  proc_id;
    logic [63:0] addr;
    logic        ok;
    logic [31:0] now;
    logic [31:0] val;
    bit          fixed;
    logic [2:0]  status;
    logic [8:0]  woken;
  } dir_row_t;

  // Rows marked fixed carry a reply that is obvious from the request alone.
  dir_row_t dir_rows [NDIR] = '{
    '{CMD_LEAVE, 8'h00, 64'h0,                  1'b1, 32'h0,        32'h0,
      1'b1, ST_OK, 9'd0},
    '{CMD_WAIT,  8'h01, 64'h1000,               1'b0, 32'h7,        32'h7,
      1'b1, ST_FAULT, 9'd0},
    '{CMD_WAIT,  8'h01, 64'h1001,               1'b1, 32'h7,        32'h7,
      1'b1, ST_FAULT, 9'd0},
    '{CMD_WAKE,  8'h01, 64'h1002,               1'b1, 32'h0,        32'h1,
      1'b1, ST_FAULT, 9'd0},
    '{CMD_BAD,   8'h01, 64'h1003,               1'b1, 32'h0,        32'h0,
      1'b1, ST_FAULT, 9'd0},
    '{CMD_BAD,   8'h01, 64'h1004,               1'b0, 32'h0,        32'h0,
      1'b1, ST_FAULT, 9'd0},
    '{CMD_BAD,   8'h01, 64'h1004,               1'b1, 32'h0,        32'h0,
      1'b1, ST_UNSUPPORTED, 9'd0},
    '{CMD_WAIT,  8'h02, 64'h1000,               1'b1, 32'h5,        32'h6,
      1'b1, ST_MISMATCH, 9'd0},
    '{CMD_WAIT,  8'h00, 64'h0,                  1'b1, 32'h0,        32'h0,
      1'b1, ST_OK, 9'd0},
    '{CMD_WAIT,  8'hFF, 64'hFFFF_FFFF_FFFF_FFFC, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      1'b1, ST_OK, 9'd0},
    '{CMD_WAIT,  8'hFF, 64'h0,                  1'b1, 32'hAAAA_5555, 32'hAAAA_5555,
      1'b1, ST_OK, 9'd0},
    '{CMD_WAKE,  8'h00, 64'h0,                  1'b1, 32'h0,        32'h8000_0000,
      1'b1, ST_OK, 9'd0},
    '{CMD_WAKE,  8'h00, 64'h0,                  1'b1, 32'h0,        32'hFFFF_FFFF,
      1'b1, ST_OK, 9'd0},
    '{CMD_WAKE,  8'h00, 64'h0,                  1'b1, 32'h0,        32'h0,
      1'b1, ST_OK, 9'd0},
    '{CMD_WAKE,  8'h00, 64'h0,                  1'b1, 32'h0,        32'h1,
      1'b0, ST_OK, 9'd0},
    '{CMD_WAKE,  8'h00, 64'h0,                  1'b1, 32'h0,        32'h7FFF_FFFF,
      1'b0, ST_OK, 9'd0},
    '{CMD_LEAVE, 8'hFF, 64'h3,                  1'b0, 32'h0,        32'h0,
      1'b0, ST_OK, 9'd0},
    '{CMD_WAKE,  8'h00, 64'hFFFF_FFFF_FFFF_FFFC, 1'b1, 32'h0,        32'h7FFF_FFFF,
      1'b0, ST_OK, 9'd0}
  };

  // Applies one request to the shadow slots and returns the reply it earns.
  function automatic fwt_rsp_t table_reply(fwt_req_t w);
    fwt_rsp_t             r;
    logic [PROC_BITS-1:0] pid;
    int                   freed;
    r.status = ST_OK;
    r.woken  = '0;
    freed    = 0;
    pid      = w.proc_id[PROC_BITS-1:0];
    if (w.cmd == CMD_LEAVE) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_busy[i] && slot_proc[i] == pid) begin
          slot_busy[i] = 1'b0;
          break;
        end
      end
    end else if (!w.addr_ok || w.word_addr[1:0] != 2'b00) begin
      r.status = ST_FAULT;
    end else if (w.cmd == CMD_WAIT) begin
      if (w.word_now != w.value) begin
        r.status = ST_MISMATCH;
      end else begin
        r.status = ST_FULL;
        for (int i = 0; i < ENTRIES; i++) begin
          if (!slot_busy[i]) begin
            slot_busy[i] = 1'b1;
            slot_proc[i] = pid;
            slot_addr[i] = w.word_addr;
            r.status     = ST_OK;
            break;
          end
        end
        if (r.status == ST_FULL) full_replies++;
      end
    end else if (w.cmd == CMD_WAKE) begin
      // A count with the top bit set is negative to the caller and frees nothing.
      if (!w.value[31]) begin
        for (int i = 0; i < ENTRIES && freed < w.value; i++) begin
          if (slot_busy[i] && slot_addr[i] == w.word_addr) begin
            slot_busy[i] = 1'b0;
            freed++;
          end
        end
      end
    end else begin
      r.status = ST_UNSUPPORTED;
    end
    if (freed > WOKEN_MAX) freed = WOKEN_MAX;
    if (freed > most_woken) most_woken = freed;
    r.woken = 9'(freed);
    return r;
  endfunction

  function automatic void refresh_pools();
    for (int i = 0; i < 8; i++) addr_pool[i] = {$urandom, $urandom} & ~64'h3;
    for (int i = 0; i < 16; i++) proc_pool[i] = 8'($urandom);
  endfunction

  // Mostly well-formed traffic on a few shared addresses, with some noise.
  function automatic fwt_req_t random_request();
    fwt_req_t w;
    int       r;
    r           = $urandom_range(0, 99);
    w.proc_id   = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                              : proc_pool[$urandom_range(0, 15)];
    w.word_addr = addr_pool[$urandom_range(0, 7)];
    w.addr_ok   = 1'b1;
    w.word_now  = $urandom;
    w.value     = w.word_now;
    if (r < 45) begin
      w.cmd = CMD_WAIT;
      if ($urandom_range(0, 9) == 0) w.value = $urandom;
    end else if (r < 75) begin
      w.cmd = CMD_WAKE;
      case ($urandom_range(0, 4))
        0:       w.value = 32'd0;
        1, 2:    w.value = $urandom_range(1, 3);
        3:       w.value = $urandom_range(4, 300);
        default: w.value = $urandom;
      endcase
    end else if (r < 88) begin
      w.cmd       = CMD_LEAVE;
      w.word_addr = {$urandom, $urandom};
      w.addr_ok   = 1'($urandom_range(0, 1));
    end else begin
      w.cmd       = 2'($urandom_range(0, 3));
      w.word_addr = {$urandom, $urandom};
      w.addr_ok   = 1'($urandom_range(0, 1));
      w.word_now  = $urandom;
      w.value     = $urandom;
    end
    return w;
  endfunction

  task automatic report(string what);
    errors++;
    if (errors <= 10) $display("%s", what);
  endtask

  // Called at a rising edge; returns at the edge where the word was taken.
  task automatic send_word(input fwt_req_t w, input bit fixed = 1'b0,
                           input fwt_rsp_t fixed_rsp = '0);
    fwt_rsp_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= w;
    do @(posedge clk_i); while (in_stall_o);
    r = table_reply(w);
    replies_due.push_back(fixed ? fixed_rsp : r);
    words_sent++;
  endtask

  task automatic quiesce();
    in_valid_i <= 1'b0;
    wait (replies_due.size() == 0);
    @(posedge clk_i);
  endtask

  task automatic run_random(int n);
    for (int k = 0; k < n; k++) send_word(random_request());
  endtask

  // Empties the table by waking each address still held, then fills every slot
  // with one address so the next wait is refused and one wake frees them all.
  task automatic fill_and_flush();
    fwt_req_t w;
    int       idx;
    w.addr_ok = 1'b1;
    w.cmd     = CMD_WAKE;
    do begin
      idx = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_busy[i]) begin
          idx = i;
          break;
        end
      end
      if (idx >= 0) begin
        w.proc_id   = 8'($urandom);
        w.word_addr = slot_addr[idx];
        w.word_now  = $urandom;
        w.value     = 32'h7FFF_FFFF;
        send_word(w);
      end
    end while (idx >= 0);
    w.cmd       = CMD_WAIT;
    w.word_addr = addr_pool[0];
    for (int k = 0; k <= ENTRIES; k++) begin
      w.proc_id  = proc_pool[$urandom_range(0, 15)];
      w.word_now = $urandom;
      w.value    = w.word_now;
      send_word(w);
    end
    w.cmd = CMD_LEAVE;
    send_word(w);
    w.cmd = CMD_WAIT;
    send_word(w);
    w.cmd   = CMD_WAKE;
    w.value = 32'd300;
    send_word(w);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Run stopped after %0d cycles with %0d replies outstanding.",
                 cycles, replies_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Receiver stalls; a bump of hold_seq starts one long hold-off.
  initial begin
    int seen_seq;
    int hold_left;
    seen_seq    = 0;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seq != seen_seq) begin
        seen_seq  = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    fwt_rsp_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      replies_seen++;
      if (replies_due.size() == 0) begin
        report($sformatf("Unexpected reply word: status %0d woken %0d",
                         out_rsp_o.status, out_rsp_o.woken));
      end else begin
        due = replies_due.pop_front();
        if (out_rsp_o.status !== due.status)
          report($sformatf("Reply %0d status: expected %0d, got %0d",
                           replies_seen, due.status, out_rsp_o.status));
        if (out_rsp_o.woken !== due.woken)
          report($sformatf("Reply %0d woken: expected %0d, got %0d",
                           replies_seen, due.woken, out_rsp_o.woken));
      end
    end
  end

  initial begin
    fwt_req_t w;
    fwt_rsp_t fixed_rsp;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_req_i   = '0;
    refresh_pools();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 16;
    recv_idle_pct = 78;
    for (int k = 0; k < NDIR; k++) begin
      w.cmd            = dir_rows[k].cmd;
      w.proc_id        = dir_rows[k].proc_id;
      w.word_addr      = dir_rows[k].addr;
      w.addr_ok        = dir_rows[k].ok;
      w.word_now       = dir_rows[k].now;
      w.value          = dir_rows[k].val;
      fixed_rsp.status = dir_rows[k].status;
      fixed_rsp.woken  = dir_rows[k].woken;
      send_word(w, dir_rows[k].fixed, fixed_rsp);
    end
    hold_seq++;
    run_random(PHASE_ITEMS);
    quiesce();

    send_idle_pct = 78;
    recv_idle_pct = 16;
    refresh_pools();
    fill_and_flush();
    run_random(PHASE_ITEMS);
    quiesce();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    refresh_pools();
    hold_seq++;
    run_random(PHASE_ITEMS);

    in_valid_i <= 1'b0;
    wait (replies_due.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Sent %0d request words and checked %0d reply words in %0d cycles.",
             words_sent, replies_seen, cycles);
    $display("Table-full refusals: %0d; largest single wake: %0d; mismatches: %0d.",
             full_replies, most_woken, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[futex_waiter_table_top.f]
rtl/core/fwt_pkg.sv
rtl/core/fwt_datapath.sv
rtl/core/fwt_ctrl.sv
rtl/core/futex_waiter_table_top.sv
tb/tb.sv
